@@ hdl/fkv_pkg.sv @@
// Shared types, constants and helpers of the flat key/value directory engine.
package fkv_pkg;

  localparam int MAX_ENTRIES_DEF  = 32;
  localparam int REGION_BYTES_DEF = 65536;
  localparam int SECTOR_BYTES_DEF = 4096;
  localparam int KEY_BYTES_DEF    = 32;

  localparam int SLOT_MAX_W = 8;
  localparam int ADDR_W     = 23;
  localparam int SIZE_W     = 16;

  localparam logic [2:0] FUNC_SAVE   = 3'd0;
  localparam logic [2:0] FUNC_LOAD   = 3'd1;
  localparam logic [2:0] FUNC_EXISTS = 3'd2;
  localparam logic [2:0] FUNC_DELETE = 3'd3;
  localparam logic [2:0] FUNC_FORMAT = 3'd4;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_INVALID   = 3'd1;
  localparam logic [2:0] ST_KEY_LONG  = 3'd2;
  localparam logic [2:0] ST_NO_SPACE  = 3'd3;
  localparam logic [2:0] ST_DIR_FULL  = 3'd4;
  localparam logic [2:0] ST_NOT_FOUND = 3'd5;

  localparam logic CFG_REGION_BASE = 1'b0;
  localparam logic CFG_MOUNTED     = 1'b1;

  typedef logic [255:0] key_t;

  typedef struct packed {
    logic                  vld;
    logic                  found;
    logic [SLOT_MAX_W-1:0] fslot;
    logic [ADDR_W-1:0]     foffs;
    logic [SIZE_W-1:0]     flen;
    logic                  has_free;
    logic [SLOT_MAX_W-1:0] free_slot;
  } scan_t;

  typedef struct packed {
    logic                  set;
    logic                  clr_one;
    logic                  clr_all;
    logic [SLOT_MAX_W-1:0] slot;
    key_t                  key;
    logic [ADDR_W-1:0]     offs;
    logic [SIZE_W-1:0]     len;
  } wr_t;

  typedef struct packed {
    key_t key;
    logic ended;
  } norm_t;

  // Clears every byte from the first zero byte on and every byte at or past key_bytes.
  function automatic norm_t norm_key(key_t raw, int key_bytes);
    norm_t res;
    logic  stop;
    res.key   = '0;
    res.ended = 1'b0;
    stop      = 1'b0;
    for (int i = 0; i < 32; i++) begin
      if (i >= key_bytes) stop = 1'b1;
      if (!stop && raw[i*8 +: 8] == 8'd0) begin
        res.ended = 1'b1;
        stop      = 1'b1;
      end
      if (!stop) res.key[i*8 +: 8] = raw[i*8 +: 8];
    end
    return res;
  endfunction

endpackage

@@ hdl/fkv_if.sv @@
// Valid/ready channel interfaces for requests and results.
interface fkv_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [63:0] key_word0;
  logic [63:0] key_word1;
  logic [63:0] key_word2;
  logic [63:0] key_word3;
  logic [15:0] req_size;
  modport source(output valid, func, key_word0, key_word1, key_word2, key_word3, req_size,
                 input ready);
  modport sink(input valid, func, key_word0, key_word1, key_word2, key_word3, req_size,
               output ready);
endinterface

interface fkv_out_if;
  logic        valid;
  logic        ready;
  logic        ok;
  logic [2:0]  status;
  logic [4:0]  slot;
  logic [22:0] flash_addr;
  logic [15:0] length;
  logic [5:0]  num_entries;
  logic [15:0] free_bytes;
  modport source(output valid, ok, status, slot, flash_addr, length, num_entries, free_bytes,
                 input ready);
  modport sink(input valid, ok, status, slot, flash_addr, length, num_entries, free_bytes,
               output ready);
endinterface

@@ hdl/fkv_cell.sv @@
// One directory slot: holds its entry and updates the passing search record.
module fkv_cell #(
  parameter int IDX = 0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  fkv_pkg::key_t key_i,
  input  fkv_pkg::wr_t  wr_i,
  input  fkv_pkg::scan_t scan_i,
  output fkv_pkg::scan_t scan_o
);
  import fkv_pkg::*;

  logic                  valid_r;
  key_t                  key_r;
  logic [ADDR_W-1:0]     offs_r;
  logic [SIZE_W-1:0]     len_r;
  scan_t                 scan_r;
  scan_t                 scan_nxt;
  logic                  hit;
  logic                  match;

  assign hit   = (wr_i.slot == SLOT_MAX_W'(IDX));
  assign match = valid_r && (key_r == key_i);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (wr_i.clr_all) begin
      valid_r <= 1'b0;
    end else if (wr_i.set && hit) begin
      valid_r <= 1'b1;
    end else if (wr_i.clr_one && hit) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_i.set && hit) begin
      key_r  <= wr_i.key;
      offs_r <= wr_i.offs;
      len_r  <= wr_i.len;
    end
  end

  always_comb begin
    scan_nxt = scan_i;
    if (scan_i.vld) begin
      if (!scan_i.found && match) begin
        scan_nxt.found = 1'b1;
        scan_nxt.fslot = SLOT_MAX_W'(IDX);
        scan_nxt.foffs = offs_r;
        scan_nxt.flen  = len_r;
      end
      if (!scan_i.has_free && !valid_r) begin
        scan_nxt.has_free  = 1'b1;
        scan_nxt.free_slot = SLOT_MAX_W'(IDX);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r <= '0;
    end else begin
      scan_r <= scan_nxt;
    end
  end

  assign scan_o = scan_r;
endmodule

@@ hdl/flat_kv_directory_engine.sv @@
// Top level: request control, chain of directory cells and result register.
//
// Requests arrive on in_chan and results leave on out_chan, both valid/ready;
// a transaction moves when valid and ready are high at a rising edge of clk.
// Every request gives exactly one result. The block works on one request at
// a time: after the accept, a search record walks the chain of MAX_ENTRIES
// cells, one cell per cycle; the record from the last cell is registered in
// res_r and the result is then loaded into the output register. A new request
// is taken only after that load, so the chain length sets the request rate.
// The result sits in an output register; the next request is accepted while
// it waits, and a stalled receiver only holds back the following result.
// The configuration port writes region_base (index 0) or mounted (index 1)
// on any edge with cfg_we high; write it only while the block is idle.
// Synchronous reset with rst_n low empties the directory, sets region_base
// to zero and mounted to one, and drops out_chan.valid.
module flat_kv_directory_engine #(
  parameter int MAX_ENTRIES  = fkv_pkg::MAX_ENTRIES_DEF,
  parameter int REGION_BYTES = fkv_pkg::REGION_BYTES_DEF,
  parameter int SECTOR_BYTES = fkv_pkg::SECTOR_BYTES_DEF,
  parameter int KEY_BYTES    = fkv_pkg::KEY_BYTES_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  fkv_in_if.sink        in_chan,
  fkv_out_if.source     out_chan,
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic [22:0]   cfg_data
);
  import fkv_pkg::*;

  localparam int DATA_BYTES = (REGION_BYTES > SECTOR_BYTES) ? REGION_BYTES - SECTOR_BYTES : 0;
  localparam int OFS_W0     = $clog2(DATA_BYTES + 1);
  localparam int OFS_W      = (OFS_W0 < 1) ? 1 : OFS_W0;
  localparam int SUM_W      = ((OFS_W > SIZE_W) ? OFS_W : SIZE_W) + 1;
  localparam int CNT_W      = $clog2(MAX_ENTRIES + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]          state_r, state_nxt;
  logic                start_r;
  logic [22:0]         region_base_r;
  logic                mounted_r;
  logic [2:0]          func_r;
  key_t                key_r;
  logic                ended_r;
  logic [SIZE_W-1:0]   size_r;
  scan_t               res_r;
  logic [OFS_W-1:0]    ap_r, ap_nxt;
  logic [OFS_W-1:0]    used_r, used_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  norm_t               norm;
  wr_t                 wr;
  scan_t               chain [MAX_ENTRIES+1];
  logic                in_acc;
  logic                emit;

  logic                out_valid_r;
  logic                ok_r, ok_nxt;
  logic [2:0]          status_r, status_nxt;
  logic [4:0]          slot_r, slot_nxt;
  logic [22:0]         faddr_r, faddr_nxt;
  logic [15:0]         len_r, len_nxt;
  logic [5:0]          count_r;
  logic [15:0]         free_r;

  logic [SUM_W-1:0]    end_sum;
  logic [SUM_W-1:0]    used_sum;
  logic [SLOT_MAX_W-1:0] tgt_slot;
  logic [22:0]         base_sec;

  assign norm = norm_key({in_chan.key_word3, in_chan.key_word2, in_chan.key_word1,
                          in_chan.key_word0}, KEY_BYTES);
  assign in_chan.ready = (state_r == S_IDLE);
  assign in_acc = in_chan.valid && in_chan.ready;
  assign emit = (state_r == S_DONE) && (!out_valid_r || out_chan.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region_base_r <= '0;
      mounted_r     <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_REGION_BASE: region_base_r <= cfg_data;
        CFG_MOUNTED:     mounted_r     <= cfg_data[0];
        default:         ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      func_r  <= in_chan.func;
      key_r   <= norm.key;
      ended_r <= norm.ended;
      size_r  <= in_chan.req_size;
    end
    if (chain[MAX_ENTRIES].vld) res_r <= chain[MAX_ENTRIES];
  end

  assign chain[0] = '{vld: start_r, default: '0};

  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    fkv_cell #(.IDX(g)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .key_i  (key_r),
      .wr_i   (wr),
      .scan_i (chain[g]),
      .scan_o (chain[g+1])
    );
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_acc) state_nxt = S_SCAN;
      S_SCAN:  if (chain[MAX_ENTRIES].vld) state_nxt = S_DONE;
      S_DONE:  if (emit) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  assign base_sec = region_base_r + 23'(SECTOR_BYTES);
  assign end_sum  = SUM_W'(ap_r) + SUM_W'(size_r);
  assign used_sum = SUM_W'(used_r) - SUM_W'(res_r.flen) + SUM_W'(size_r);
  assign tgt_slot = res_r.found ? res_r.fslot : res_r.free_slot;

  always_comb begin
    ok_nxt     = 1'b0;
    status_nxt = ST_INVALID;
    slot_nxt   = '0;
    faddr_nxt  = '0;
    len_nxt    = '0;
    ap_nxt     = ap_r;
    used_nxt   = used_r;
    cnt_nxt    = cnt_r;
    wr         = '0;
    wr.key     = key_r;
    wr.offs    = ADDR_W'(ap_r);
    wr.len     = size_r;
    wr.slot    = tgt_slot;
    if (mounted_r) begin
      case (func_r)
        FUNC_SAVE: begin
          if (size_r == '0) begin
            status_nxt = ST_INVALID;
          end else if (!ended_r) begin
            status_nxt = ST_KEY_LONG;
          end else if (end_sum > SUM_W'(DATA_BYTES)) begin
            status_nxt = ST_NO_SPACE;
          end else if (!res_r.found && !res_r.has_free) begin
            status_nxt = ST_DIR_FULL;
          end else begin
            wr.set     = emit;
            ok_nxt     = 1'b1;
            status_nxt = ST_OK;
            slot_nxt   = 5'(tgt_slot);
            faddr_nxt  = base_sec + 23'(ap_r);
            len_nxt    = size_r;
            ap_nxt     = OFS_W'(end_sum);
            if (res_r.found) begin
              used_nxt = OFS_W'(used_sum);
            end else begin
              used_nxt = OFS_W'(SUM_W'(used_r) + SUM_W'(size_r));
              cnt_nxt  = cnt_r + 1'b1;
            end
          end
        end
        FUNC_LOAD: begin
          if (size_r == '0) begin
            status_nxt = ST_INVALID;
          end else if (!res_r.found) begin
            status_nxt = ST_NOT_FOUND;
          end else begin
            ok_nxt     = 1'b1;
            status_nxt = ST_OK;
            slot_nxt   = 5'(res_r.fslot);
            faddr_nxt  = base_sec + res_r.foffs;
            len_nxt    = (size_r < res_r.flen) ? size_r : res_r.flen;
          end
        end
        FUNC_EXISTS: begin
          if (!res_r.found) begin
            status_nxt = ST_NOT_FOUND;
          end else begin
            ok_nxt     = 1'b1;
            status_nxt = ST_OK;
            slot_nxt   = 5'(res_r.fslot);
            faddr_nxt  = base_sec + res_r.foffs;
          end
        end
        FUNC_DELETE: begin
          if (!res_r.found) begin
            status_nxt = ST_NOT_FOUND;
          end else begin
            wr.clr_one = emit;
            wr.slot    = res_r.fslot;
            ok_nxt     = 1'b1;
            status_nxt = ST_OK;
            slot_nxt   = 5'(res_r.fslot);
            used_nxt   = OFS_W'(SUM_W'(used_r) - SUM_W'(res_r.flen));
            cnt_nxt    = cnt_r - 1'b1;
          end
        end
        FUNC_FORMAT: begin
          wr.clr_all = emit;
          ok_nxt     = 1'b1;
          status_nxt = ST_OK;
          ap_nxt     = '0;
          used_nxt   = '0;
          cnt_nxt    = '0;
        end
        default: status_nxt = ST_INVALID;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      start_r     <= 1'b0;
      ap_r        <= '0;
      used_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      start_r <= in_acc;
      if (emit) begin
        ap_r        <= ap_nxt;
        used_r      <= used_nxt;
        cnt_r       <= cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      ok_r     <= ok_nxt;
      status_r <= status_nxt;
      slot_r   <= slot_nxt;
      faddr_r  <= faddr_nxt;
      len_r    <= len_nxt;
      count_r  <= 6'(cnt_nxt);
      free_r   <= (SUM_W'(used_nxt) < SUM_W'(DATA_BYTES))
                  ? 16'(SUM_W'(DATA_BYTES) - SUM_W'(used_nxt)) : 16'd0;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.ok          = ok_r;
  assign out_chan.status      = status_r;
  assign out_chan.slot        = slot_r;
  assign out_chan.flash_addr  = faddr_r;
  assign out_chan.length      = len_r;
  assign out_chan.num_entries = count_r;
  assign out_chan.free_bytes  = free_r;
endmodule
